### hdl/mpnd_pkg.sv
// Package for the multichannel peak note detector.
// Holds the sizing constants, register codes and the note queue entry type.
// No dependencies.
package mpnd_pkg;

    localparam int CHANNELS          = 16;
    localparam int SAMPLE_BITS       = 10;

    localparam int CHANNEL_BITS      = 4;
    localparam int SAMPLE_FIELD_BITS = 10;
    localparam int VELOCITY_BITS     = 10;
    localparam int THRESHOLD_BITS    = 10;
    localparam int SHIFT_BITS        = 3;

    localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_WIDE_BITS = (CH_IDX_BITS > CHANNEL_BITS) ? CH_IDX_BITS : CHANNEL_BITS;
    localparam int SMP_BITS = (SAMPLE_BITS < SAMPLE_FIELD_BITS) ? SAMPLE_BITS
                                                                : SAMPLE_FIELD_BITS;

    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = THRESHOLD_BITS'(250);
    localparam logic [SHIFT_BITS-1:0]     SHIFT_RESET     = SHIFT_BITS'(3);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic {
        REG_PEAK_THRESHOLD = 1'b0,
        REG_VELOCITY_SHIFT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0]      channel;
        logic [SAMPLE_FIELD_BITS-1:0] peak;
    } t_note_entry;

    typedef struct packed {
        logic        valid;
        t_note_entry entry;
    } t_note_push;

endpackage

### hdl/mpnd_if.sv
// Valid/ready channel interfaces for the peak note detector.
// Depends on mpnd_pkg for the field widths.
interface mpnd_sample_if
    import mpnd_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic [CHANNEL_BITS-1:0]      channel;
    logic [SAMPLE_FIELD_BITS-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mpnd_note_if
    import mpnd_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CHANNEL_BITS-1:0]  note_channel;
    logic [VELOCITY_BITS-1:0] note_velocity;

    modport source (output valid, output note_channel, output note_velocity, input ready);
    modport sink   (input valid, input note_channel, input note_velocity, output ready);
endinterface

### hdl/multichannel_peak_note_detector.sv
// Multichannel peak note detector takes one sample beat per clock on i_in and emits a
// note beat on o_note each time a channel's sample series turns from rising to
// not rising above peak_threshold; the velocity is the peak sample shifted right by
// velocity_shift. After a note the channel ignores samples until one falls below
// peak_threshold. Rate: one sample per cycle, sustained; per-channel state lives in
// flip-flops and is read, updated and written in the accepting cycle, so samples of
// the same channel may follow each other directly. Notes pass through a 4-entry
// queue and an output register, so i_in.ready drops only when that queue is full;
// each note reaches o_note through that queue and then the output register.
// Depends on mpnd_pkg, mpnd_if, mpnd_front, mpnd_queue and mpnd_back.
module multichannel_peak_note_detector
    import mpnd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    mpnd_sample_if.sink              i_in,
    mpnd_note_if.source              o_note,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [THRESHOLD_BITS-1:0] r_threshold;
    logic [SHIFT_BITS-1:0]     r_shift;
    t_reg_idx                  reg_idx;
    logic                      cfg_write;

    t_note_push  push;
    logic        q_full;
    logic        q_valid;
    t_note_entry q_entry;
    logic        pop;

    // Registers sit at byte addresses 0 and 4; pready is tied high.
    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_shift     <= SHIFT_RESET;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_PEAK_THRESHOLD: r_threshold <= pwdata[THRESHOLD_BITS-1:0];
                REG_VELOCITY_SHIFT: r_shift     <= pwdata[SHIFT_BITS-1:0];
                default:            r_shift     <= r_shift;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PEAK_THRESHOLD: prdata = APB_DATA_BITS'(r_threshold);
            REG_VELOCITY_SHIFT: prdata = APB_DATA_BITS'(r_shift);
            default:            prdata = '0;
        endcase
    end

    // Classify each sample beat and push peaks.
    mpnd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .i_channel    (i_in.channel),
        .i_sample     (i_in.sample),
        .i_queue_full (q_full),
        .i_threshold  (r_threshold),
        .o_ready      (i_in.ready),
        .o_push       (push)
    );

    // Buffer notes so the input side keeps running while o_note stalls.
    mpnd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // Shift to velocity and hold the note beat until taken.
    mpnd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_entry),
        .i_shift    (r_shift),
        .i_ready    (o_note.ready),
        .o_pop      (pop),
        .o_valid    (o_note.valid),
        .o_channel  (o_note.note_channel),
        .o_velocity (o_note.note_velocity)
    );

endmodule

### hdl/mpnd_front.sv
// Front end: accepts samples, keeps per-channel slope state, detects peaks.
// Depends on mpnd_pkg; pushes peak entries into mpnd_queue.
module mpnd_front
    import mpnd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [CHANNEL_BITS-1:0]      i_channel,
    input  logic [SAMPLE_FIELD_BITS-1:0] i_sample,
    input  logic                         i_queue_full,
    input  logic [THRESHOLD_BITS-1:0]    i_threshold,
    output logic                         o_ready,
    output t_note_push                   o_push
);

    logic [SMP_BITS-1:0] r_prev   [CHANNELS];
    logic [CHANNELS-1:0] r_rising;
    logic [CHANNELS-1:0] r_wait;

    logic [CH_WIDE_BITS-1:0]   ch_wide;
    logic [CH_IDX_BITS-1:0]    idx;
    logic                      in_range;
    logic                      accept;
    logic [SMP_BITS-1:0]       smp;
    logic [SMP_BITS-1:0]       old;
    logic [THRESHOLD_BITS-1:0] smp_ext;
    logic [THRESHOLD_BITS-1:0] old_ext;
    logic                      rising;
    logic                      peak;

    assign o_ready  = !i_queue_full;
    assign accept   = i_valid && o_ready;
    assign ch_wide  = CH_WIDE_BITS'(i_channel);
    assign idx      = ch_wide[CH_IDX_BITS-1:0];
    assign in_range = int'(ch_wide) < CHANNELS;
    assign smp      = i_sample[SMP_BITS-1:0];
    assign old      = r_prev[idx];
    assign smp_ext  = THRESHOLD_BITS'(smp);
    assign old_ext  = THRESHOLD_BITS'(old);
    assign rising   = smp > old;
    assign peak     = r_rising[idx] && !rising && (old_ext > i_threshold);

    always_comb begin
        o_push.valid         = accept && in_range && !r_wait[idx] && peak;
        o_push.entry.channel = i_channel;
        o_push.entry.peak    = SAMPLE_FIELD_BITS'(old);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_prev[c] <= '0;
            end
            r_rising <= '0;
            r_wait   <= '0;
        end else if (accept && in_range) begin
            if (r_wait[idx]) begin
                // Rearm once the sample drops below the threshold.
                if (smp_ext < i_threshold) begin
                    r_wait[idx] <= 1'b0;
                end
            end else begin
                r_prev[idx]   <= smp;
                r_rising[idx] <= rising;
                if (peak) begin
                    r_wait[idx] <= 1'b1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_push_sets_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |=> r_wait[$past(idx)])
        else $error("peak did not put the channel into the rearm wait");

    a_no_push_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_wait[idx]) |-> !o_push.valid)
        else $error("note pushed for a channel waiting to rearm");
`endif

endmodule

### hdl/mpnd_queue.sv
// Short note queue between the detector front end and the output stage.
// Depends on mpnd_pkg for the entry type and depth.
module mpnd_queue
    import mpnd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_note_push  i_push,
    input  logic        i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_note_entry o_entry
);

    t_note_entry          r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QCNT_BITS-1:0] n_count;

    assign o_full  = r_count == QCNT_BITS'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !(i_pop && o_valid)) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && i_pop && o_valid) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= QPTR_BITS'(r_wr_ptr + 1'b1);
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= QPTR_BITS'(r_rd_ptr + 1'b1);
            end
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.valid)
        else $error("push into a full note queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("note queue count beyond depth");
`endif

endmodule

### hdl/mpnd_back.sv
// Back end: forms the velocity and holds the note in the output register.
// Depends on mpnd_pkg; drains mpnd_queue.
module mpnd_back
    import mpnd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  t_note_entry              i_q_entry,
    input  logic [SHIFT_BITS-1:0]    i_shift,
    input  logic                     i_ready,
    output logic                     o_pop,
    output logic                     o_valid,
    output logic [CHANNEL_BITS-1:0]  o_channel,
    output logic [VELOCITY_BITS-1:0] o_velocity
);

    logic                     r_valid;
    logic [CHANNEL_BITS-1:0]  r_channel;
    logic [VELOCITY_BITS-1:0] r_velocity;

    // Load when the output register is empty or being drained this cycle.
    assign o_pop      = i_q_valid && (!r_valid || i_ready);
    assign o_valid    = r_valid;
    assign o_channel  = r_channel;
    assign o_velocity = r_velocity;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_channel  <= i_q_entry.channel;
            r_velocity <= VELOCITY_BITS'(i_q_entry.peak >> i_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

### tb/sv/mpnd_note_checker.sv
`timescale 1ns / 1ps
// Note checker for the multichannel peak note detector: watches the sample, note and
// register ports, predicts every note and compares it with what the block emits.
// Depends on mpnd_pkg and the channel interfaces in mpnd_if.
module mpnd_note_checker
    import mpnd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    mpnd_sample_if                   i_in,
    mpnd_note_if                     i_note,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    input  logic                     pready,
    output int                       o_fail_count,
    output int                       o_pending_notes,
    output int                       o_samples_seen,
    output int                       o_notes_seen
);

    localparam int MAX_REPORTS = 10;
    localparam logic [SAMPLE_FIELD_BITS-1:0] LEVEL_MASK =
        SAMPLE_FIELD_BITS'((1 << SMP_BITS) - 1);

    typedef struct packed {
        logic [CHANNEL_BITS-1:0]  channel;
        logic [VELOCITY_BITS-1:0] velocity;
    } t_note_beat;

    logic [THRESHOLD_BITS-1:0]    threshold;
    logic [SHIFT_BITS-1:0]        vel_shift;
    logic [SAMPLE_FIELD_BITS-1:0] last_level [CHANNELS];
    logic                         slope_up   [CHANNELS];
    logic                         rearm_wait [CHANNELS];
    t_note_beat                   expected_notes [$];

    int fail_total    = 0;
    int pending_total = 0;
    int sample_total  = 0;
    int note_total    = 0;

    assign o_fail_count    = fail_total;
    assign o_pending_notes = pending_total;
    assign o_samples_seen  = sample_total;
    assign o_notes_seen    = note_total;

    // Advance one channel's peak search by one sample; queue a note on a peak.
    function automatic void track_peak(input logic [CHANNEL_BITS-1:0] ch,
                                       input logic [SAMPLE_FIELD_BITS-1:0] raw);
        logic [SAMPLE_FIELD_BITS-1:0] level;
        logic [SAMPLE_FIELD_BITS-1:0] held;
        logic                         rising;
        t_note_beat                   beat;
        level = raw & LEVEL_MASK;
        if (int'(ch) >= CHANNELS)
            return;
        if (rearm_wait[ch]) begin
            if (level < threshold)
                rearm_wait[ch] = 1'b0;
            return;
        end
        held           = last_level[ch];
        rising         = level > held;
        last_level[ch] = level;
        if (slope_up[ch] && !rising && held > threshold) begin
            rearm_wait[ch] = 1'b1;
            beat.channel   = ch;
            beat.velocity  = VELOCITY_BITS'(held >> vel_shift);
            expected_notes.push_back(beat);
        end
        slope_up[ch] = rising;
    endfunction

    function automatic void report(input string what);
        if (fail_total < MAX_REPORTS)
            $display("[%0t] note mismatch: %s", $time, what);
        fail_total++;
    endfunction

    always @(posedge i_clk) begin
        t_note_beat want;
        int         reg_index;
        if (!i_rst_n) begin
            threshold = THRESHOLD_RESET;
            vel_shift = SHIFT_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                last_level[c] = '0;
                slope_up[c]   = 1'b0;
                rearm_wait[c] = 1'b0;
            end
            expected_notes.delete();
        end else begin
            // compare the outgoing note first; it always stems from an older sample
            if (i_note.valid && i_note.ready) begin
                note_total++;
                if (expected_notes.size() == 0) begin
                    report($sformatf("unexpected note ch %0d vel %0d",
                                     i_note.note_channel, i_note.note_velocity));
                end else begin
                    want = expected_notes.pop_front();
                    if (i_note.note_channel !== want.channel ||
                        i_note.note_velocity !== want.velocity)
                        report($sformatf("expected ch %0d vel %0d, got ch %0d vel %0d",
                                         want.channel, want.velocity,
                                         i_note.note_channel, i_note.note_velocity));
                end
            end
            if (i_in.valid && i_in.ready) begin
                sample_total++;
                track_peak(i_in.channel, i_in.sample);
            end
            if (psel && penable && pwrite && pready) begin
                reg_index = int'(paddr >> 2);
                if (reg_index == int'(REG_PEAK_THRESHOLD))
                    threshold = pwdata[THRESHOLD_BITS-1:0];
                else if (reg_index == int'(REG_VELOCITY_SHIFT))
                    vel_shift = pwdata[SHIFT_BITS-1:0];
            end
        end
        pending_total = expected_notes.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the peak note detector testbench: clock, reset, register writes, sample
// stimulus with bursts, note receiver with stalls, and the final verdict.
// Depends on mpnd_pkg, mpnd_if, the detector RTL and mpnd_note_checker.
module testbench;
    import mpnd_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 7;
    localparam int DRAIN_CYCLES    = 8;     // output queue plus output register
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 170;
    localparam int MAX_LEVEL       = (1 << SAMPLE_FIELD_BITS) - 1;
    localparam int MAX_CHANNEL     = CHANNELS - 1;

    // Receiver stall patterns, switched at random intervals.
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_CADENCE
    } t_rx_mode;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int fail_count;
    int pending_notes;
    int samples_seen;
    int notes_seen;

    // Stimulus bookkeeping kept in the top.
    int cur_threshold;
    int cur_shift;
    int burst_left;
    int settings_used;
    int long_holds;
    bit hold_request;

    mpnd_sample_if sample_bus ();
    mpnd_note_if   note_bus ();

    multichannel_peak_note_detector u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_bus),
        .o_note  (note_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mpnd_note_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (sample_bus),
        .i_note          (note_bus),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_fail_count    (fail_count),
        .o_pending_notes (pending_notes),
        .o_samples_seen  (samples_seen),
        .o_notes_seen    (notes_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("multichannel_peak_note_detector verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Register port: setup cycle, then access cycle; the write lands on the
    // rising edge with psel, penable, pwrite and pready all high. Junk goes
    // into the upper data bits so that the block has to mask them off.
    // ------------------------------------------------------------------
    task automatic write_reg(input t_reg_idx idx, input int value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_ADDR_BITS'(int'(idx) * 4);
        pwdata  <= {16'($urandom()), 16'(value)};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input int thr, input int shift);
        write_reg(REG_PEAK_THRESHOLD, thr);
        write_reg(REG_VELOCITY_SHIFT, shift);
        cur_threshold = thr;
        cur_shift     = shift;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Sample sender. Works in bursts: between bursts valid drops for a random
    // gap or not at all; some bursts are long and back to back to give stretches with no
    // idling at all. Valid stays high from one beat to the next inside a burst.
    // ------------------------------------------------------------------
    task automatic send_sample(input int ch, input int level);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                sample_bus.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
        end
        @(negedge i_clk);
        sample_bus.valid   <= 1'b1;
        sample_bus.channel <= CHANNEL_BITS'(ch);
        sample_bus.sample  <= SAMPLE_FIELD_BITS'(level);
        // hold the beat until the block takes it
        do @(posedge i_clk); while (!sample_bus.ready);
        burst_left--;
    endtask

    // Drop valid so that a held beat is not taken twice while the sender waits.
    task automatic stop_samples();
        @(negedge i_clk);
        sample_bus.valid <= 1'b0;
        burst_left = 0;
    endtask

    // Drain: every predicted note out, then a few cycles for samples that
    // cause no note but may still be in flight, before touching registers.
    task automatic wait_drained();
        stop_samples();
        while (pending_notes != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_noise(inout int sent);
        send_sample($urandom_range(0, MAX_CHANNEL), $urandom_range(0, MAX_LEVEL));
        sent++;
    endtask

    // ------------------------------------------------------------------
    // One strike on a random channel: a low sample to rearm, a rising ramp to a
    // peak above the threshold, a fall (sometimes to an equal level), a few
    // samples while the channel waits, and stray beats on other channels mixed
    // in. Strays may land on the same channel and break the sequence.
    // ------------------------------------------------------------------
    task automatic send_strike(inout int sent);
        int ch;
        int low;
        int peak;
        int steps;
        ch   = $urandom_range(0, MAX_CHANNEL);
        low  = (cur_threshold > 0) ? $urandom_range(0, cur_threshold - 1) : 0;
        peak = (cur_threshold < MAX_LEVEL) ? $urandom_range(cur_threshold + 1, MAX_LEVEL)
                                           : MAX_LEVEL;
        steps = $urandom_range(1, 4);
        send_sample(ch, low);
        sent++;
        for (int i = 1; i <= steps; i++) begin
            if ($urandom_range(0, 5) == 0)
                send_noise(sent);
            send_sample(ch, low + ((peak - low) * i) / steps);
            sent++;
        end
        if ($urandom_range(0, 3) == 0)
            send_sample(ch, peak);
        else
            send_sample(ch, $urandom_range(0, peak));
        sent++;
        repeat ($urandom_range(0, 2)) begin
            send_sample(ch, $urandom_range(cur_threshold, MAX_LEVEL));
            sent++;
        end
    endtask

    // Mostly well-formed strikes, the rest pure noise.
    task automatic run_random(input int items, input bit with_hold);
        int sent;
        sent = 0;
        while (sent < items) begin
            if (with_hold && sent >= 40 && long_holds == 0)
                hold_request = 1'b1;
            if ($urandom_range(0, 9) < 8)
                send_strike(sent);
            else
                send_noise(sent);
        end
    endtask

    // ------------------------------------------------------------------
    // Note receiver: its own stall pattern, plus one long hold-off on request
    // while the sender keeps going, so the note queue fills and input stalls.
    // ------------------------------------------------------------------
    initial begin : note_receiver
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        int       tick;
        mode       = RX_ALWAYS;
        mode_left  = 0;
        hold_left  = 0;
        tick       = 0;
        long_holds = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            // take the request once; the sender never clears it
            if (hold_request && long_holds == 0) begin
                hold_left = HOLD_OFF_CYCLES;
                long_holds++;
            end
            if (hold_left > 0) begin
                hold_left--;
                note_bus.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS:  note_bus.ready <= 1'b1;
                    RX_COIN:    note_bus.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:  note_bus.ready <= ($urandom_range(0, 3) == 0);
                    default:    note_bus.ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int thr;
        int shift;
        // every input known from time zero
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sample_bus.valid   = 1'b0;
        sample_bus.channel = '0;
        sample_bus.sample  = '0;
        note_bus.ready     = 1'b0;
        burst_left         = 0;
        settings_used      = 1;
        hold_request       = 1'b0;
        cur_threshold      = int'(THRESHOLD_RESET);
        cur_shift          = int'(SHIFT_RESET);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset setting: threshold 250, shift 3.
        send_sample(0, 1023);       // rising from the reset level of zero
        send_sample(0, 1023);       // equal level counts as not rising: note
        send_sample(0, 250);        // level equal to threshold does not rearm
        send_sample(0, 249);        // just below threshold rearms
        send_sample(1, 251);
        send_sample(1, 250);        // peak one above threshold: note
        send_sample(2, 250);
        send_sample(2, 0);          // peak exactly at threshold: no note
        send_sample(15, 1023);
        send_sample(15, 0);         // top channel, full-scale peak: note
        send_sample(10, 600);       // two channels interleaved
        send_sample(5, 700);
        send_sample(10, 800);
        send_sample(5, 300);        // note on channel 5
        send_sample(10, 799);       // note on channel 10
        send_sample(0, 1023);       // channel 0 searches again from a frozen history
        send_sample(0, 0);
        wait_drained();

        // Extremes first, then middle and random settings.
        apply_setting(0, 0);
        run_random(PHASE_ITEMS, 1'b0);
        wait_drained();
        apply_setting(MAX_LEVEL, 7);
        run_random(PHASE_ITEMS, 1'b0);
        wait_drained();
        apply_setting(100, 5);
        run_random(PHASE_ITEMS, 1'b1);
        wait_drained();
        apply_setting(511, 1);
        run_random(PHASE_ITEMS, 1'b0);
        wait_drained();
        apply_setting(900, 2);
        run_random(PHASE_ITEMS, 1'b0);
        repeat (2) begin
            wait_drained();
            thr   = $urandom_range(0, MAX_LEVEL);
            shift = $urandom_range(0, 7);
            apply_setting(thr, shift);
            run_random(PHASE_ITEMS, 1'b0);
        end
        wait_drained();

        $display("Covered %0d sample beats and %0d note beats over %0d register settings,",
                 samples_seen, notes_seen, settings_used);
        $display("with %0d long receiver hold-off(s) of %0d cycles and random stalls.",
                 long_holds, HOLD_OFF_CYCLES);
        if (fail_count == 0 && pending_notes == 0) begin
            $display("multichannel_peak_note_detector verification clean");
        end else begin
            $display("multichannel_peak_note_detector verification failed");
        end
        $finish;
    end

endmodule
